// ===== rtl/idfp_pkg.sv =====
// shared types and constants for the id3v2 frame stream parser
`default_nettype none

package idfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SIZE_W   = 30;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned REGION_W = 3;

    localparam logic [REGION_W-1:0] REGION_HDR   = 3'd0;
    localparam logic [REGION_W-1:0] REGION_EXT   = 3'd1;
    localparam logic [REGION_W-1:0] REGION_ID    = 3'd2;
    localparam logic [REGION_W-1:0] REGION_SIZE  = 3'd3;
    localparam logic [REGION_W-1:0] REGION_FLAGS = 3'd4;
    localparam logic [REGION_W-1:0] REGION_BODY  = 3'd5;
    localparam logic [REGION_W-1:0] REGION_DONE  = 3'd6;

    localparam logic [BYTE_W-1:0] ASCII_T = 8'h54;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [BYTE_W-1:0]   byte_out;
        logic                frame_matches;
        logic                text_frame;
        logic                encoding_byte;
        logic [SIZE_W-1:0]   frame_length;
        logic                body_last;
        logic [SIZE_W-1:0]   tag_length;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/id3v2_frame_stream_parser.sv =====
// top level of the id3v2 frame stream parser
//
// Input channel: one file byte per item on i_in_item (data_byte plus a
// start_of_file flag that restarts the parse at tag header byte zero),
// handshaked by i_in_valid / o_in_ready.
// Output channel: one labeled item per input item on o_out_item (region,
// byte, frame match, text frame, encoding byte, frame length, last body
// byte, tag length), handshaked by o_out_valid / i_out_ready.
// Configuration: i_cfg_we writes i_cfg_wdata into the four-byte frame id
// to match; write it only while no item is in flight.
// Each item is held first in the input register and then in the result
// register before it shows on the output.
// Throughput: one item per cycle while the receiver takes results; the parse
// state updates as the item moves from the input register to the result register.
// Reset clears the parse state, the match tag and both valid flags.
// When the receiver stalls, the result holds; o_in_ready drops once the
// input register is full as well, at once when items come back to back,
// and rises again in the cycle the waiting result is taken.
`default_nettype none

module id3v2_frame_stream_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [idfp_pkg::TAG_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire idfp_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output idfp_pkg::t_out_item              o_out_item
);
    import idfp_pkg::*;

    logic      stg_valid;
    t_in_item  stg_item;
    logic      res_ready;
    t_out_item result;

    idfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_ready (o_in_ready),
        .o_valid (stg_valid),
        .o_item  (stg_item),
        .i_take  (res_ready)
    );

    idfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (stg_valid && res_ready),
        .i_item      (stg_item),
        .o_result    (result)
    );

    idfp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid),
        .i_item  (result),
        .o_ready (res_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (i_out_ready)
    );

endmodule

`default_nettype wire

// ===== rtl/idfp_in_stage.sv =====
// input register stage holding one byte item
`default_nettype none

module idfp_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire idfp_pkg::t_in_item i_item,
    output logic                   o_ready,
    output logic                   o_valid,
    output idfp_pkg::t_in_item     o_item,
    input  wire logic              i_take
);
    import idfp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idfp_core.sv =====
// parse state, match tag register and per-byte labeling logic
`default_nettype none

module idfp_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [idfp_pkg::TAG_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_fire,
    input  wire idfp_pkg::t_in_item          i_item,
    output idfp_pkg::t_out_item              o_result
);
    import idfp_pkg::*;

    typedef enum logic [REGION_W-1:0] {
        PH_HDR   = REGION_HDR,
        PH_EXT   = REGION_EXT,
        PH_ID    = REGION_ID,
        PH_SIZE  = REGION_SIZE,
        PH_FLAGS = REGION_FLAGS,
        PH_BODY  = REGION_BODY,
        PH_DONE  = REGION_DONE
    } t_phase;

    t_phase              r_phase, n_phase, s_phase;
    logic [3:0]          r_pos, n_pos, s_pos;
    logic [BYTE_W-1:0]   r_ext_rem, n_ext_rem, s_ext_rem;
    logic                r_ext_pres, n_ext_pres, s_ext_pres;
    logic [TAG_W-1:0]    r_id, n_id, s_id;
    logic [SIZE_W-1:0]   r_size, n_size, s_size;
    logic [SIZE_W-1:0]   r_body_rem, n_body_rem, s_body_rem;
    logic [SIZE_W-1:0]   r_hdr_size, n_hdr_size, s_hdr_size;
    logic [TAG_W-1:0]    r_match_tag;

    logic [BYTE_W-1:0]   b;
    logic [3:0]          hdr_idx;
    logic                tag_valid;
    logic                text;
    logic [BYTE_W-1:0]   id_first;

    function automatic logic [SIZE_W-1:0] weighted(input logic [BYTE_W-1:0] v,
                                                    input logic [1:0] p);
        logic [SIZE_W-1:0] w;
        unique case (p)
            2'd0:    w = {1'b0, v, 21'b0};
            2'd1:    w = {8'b0, v, 14'b0};
            2'd2:    w = {15'b0, v, 7'b0};
            default: w = {22'b0, v};
        endcase
        return w;
    endfunction

    always_comb begin
        b = i_item.data_byte;
        if (i_item.start_of_file) begin
            s_phase    = PH_HDR;
            s_pos      = '0;
            s_ext_rem  = '0;
            s_ext_pres = 1'b0;
            s_id       = '0;
            s_size     = '0;
            s_body_rem = '0;
            s_hdr_size = '0;
        end else begin
            s_phase    = r_phase;
            s_pos      = r_pos;
            s_ext_rem  = r_ext_rem;
            s_ext_pres = r_ext_pres;
            s_id       = r_id;
            s_size     = r_size;
            s_body_rem = r_body_rem;
            s_hdr_size = r_hdr_size;
        end

        n_phase    = s_phase;
        n_pos      = s_pos;
        n_ext_rem  = s_ext_rem;
        n_ext_pres = s_ext_pres;
        n_id       = s_id;
        n_size     = s_size;
        n_body_rem = s_body_rem;
        n_hdr_size = s_hdr_size;

        hdr_idx   = s_pos - 4'd6;
        tag_valid = (s_phase != PH_HDR);
        text      = 1'b0;
        id_first  = '0;

        o_result               = '0;
        o_result.region        = s_phase;
        o_result.byte_out      = b;

        unique case (s_phase)
            PH_HDR: begin
                if (s_pos == 4'd5) begin
                    n_ext_pres = b[6];
                end
                if (s_pos == 4'd6) begin
                    n_hdr_size = weighted(b, hdr_idx[1:0]);
                end else if (s_pos >= 4'd7 && s_pos <= 4'd9) begin
                    n_hdr_size = s_hdr_size + weighted(b, hdr_idx[1:0]);
                end
                if (s_pos >= 4'd9) begin
                    tag_valid = 1'b1;
                    n_phase   = s_ext_pres ? PH_EXT : PH_ID;
                    n_pos     = '0;
                end else begin
                    n_pos = s_pos + 4'd1;
                end
            end
            PH_EXT: begin
                if (s_pos == 4'd0) begin
                    n_ext_rem = b;
                    n_pos     = 4'd1;
                    if (b == '0) begin
                        n_phase = PH_ID;
                        n_pos   = '0;
                    end
                end else begin
                    n_ext_rem = s_ext_rem - 8'd1;
                    if (n_ext_rem == '0) begin
                        n_phase = PH_ID;
                        n_pos   = '0;
                    end
                end
            end
            PH_ID: begin
                if (s_pos == 4'd0 && b == '0) begin
                    o_result.region = REGION_DONE;
                    n_phase         = PH_DONE;
                end else begin
                    n_id = {s_id[TAG_W-BYTE_W-1:0], b};
                    unique case (s_pos[1:0])
                        2'd0:    id_first = n_id[7:0];
                        2'd1:    id_first = n_id[15:8];
                        2'd2:    id_first = n_id[23:16];
                        default: id_first = n_id[31:24];
                    endcase
                    text = (id_first == ASCII_T);
                    if (s_pos >= 4'd3) begin
                        n_phase = PH_SIZE;
                        n_pos   = '0;
                    end else begin
                        n_pos = s_pos + 4'd1;
                    end
                end
            end
            PH_SIZE: begin
                o_result.frame_matches = (s_id == r_match_tag);
                text = (s_id[31:24] == ASCII_T);
                if (s_pos == 4'd0) begin
                    n_size = weighted(b, s_pos[1:0]);
                end else begin
                    n_size = s_size + weighted(b, s_pos[1:0]);
                end
                if (s_pos >= 4'd3) begin
                    n_phase = PH_FLAGS;
                    n_pos   = '0;
                end else begin
                    n_pos = s_pos + 4'd1;
                end
            end
            PH_FLAGS: begin
                o_result.frame_matches = (s_id == r_match_tag);
                text = (s_id[31:24] == ASCII_T);
                o_result.frame_length = s_size;
                if (s_pos >= 4'd1) begin
                    n_body_rem = s_size;
                    n_phase    = (s_size != '0) ? PH_BODY : PH_ID;
                    n_pos      = '0;
                end else begin
                    n_pos = s_pos + 4'd1;
                end
            end
            PH_BODY: begin
                o_result.frame_matches = (s_id == r_match_tag);
                text = (s_id[31:24] == ASCII_T);
                o_result.frame_length  = s_size;
                o_result.encoding_byte = text && (s_body_rem == s_size);
                if (s_body_rem <= 30'd1) begin
                    o_result.body_last = 1'b1;
                    n_body_rem         = '0;
                    n_phase            = PH_ID;
                    n_pos              = '0;
                end else begin
                    n_body_rem = s_body_rem - 30'd1;
                end
            end
            PH_DONE: begin
                o_result.region = REGION_DONE;
            end
            default: begin
                o_result.region = REGION_DONE;
            end
        endcase

        o_result.text_frame = text;
        o_result.tag_length = tag_valid ? n_hdr_size : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_pos       <= '0;
            r_ext_rem   <= '0;
            r_ext_pres  <= 1'b0;
            r_id        <= '0;
            r_size      <= '0;
            r_body_rem  <= '0;
            r_hdr_size  <= '0;
            r_match_tag <= '0;
        end else begin
            if (i_cfg_we) begin
                r_match_tag <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_ext_rem  <= n_ext_rem;
                r_ext_pres <= n_ext_pres;
                r_id       <= n_id;
                r_size     <= n_size;
                r_body_rem <= n_body_rem;
                r_hdr_size <= n_hdr_size;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idfp_out_stage.sv =====
// result register stage holding one labeled item
`default_nettype none

module idfp_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire idfp_pkg::t_out_item i_item,
    output logic                     o_ready,
    output logic                     o_valid,
    output idfp_pkg::t_out_item      o_item,
    input  wire logic                i_ready
);
    import idfp_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idfp_checker.sv =====
// port-level checks for the id3v2 frame stream parser and their binding
`default_nettype none

module idfp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire idfp_pkg::t_out_item         o_out_item
);
    import idfp_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // last body byte and encoding byte only inside a body
    a_body_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.body_last || o_out_item.encoding_byte)
        |-> o_out_item.region == REGION_BODY)
        else $error("body flag outside body");

    // encoding byte only for text frames
    a_enc_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.encoding_byte |-> o_out_item.text_frame)
        else $error("encoding byte outside text frame");

    // match and length only after the frame id
    a_match_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.frame_matches || o_out_item.frame_length != '0)
        |-> (o_out_item.region == REGION_SIZE || o_out_item.region == REGION_FLAGS
             || o_out_item.region == REGION_BODY))
        else $error("frame fields outside frame");

endmodule

bind id3v2_frame_stream_parser idfp_checker u_idfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
